FILE: src/rdma_pkg.sv
// Package for the range dropout moving average block.
// Holds field widths, default sizes and a shared helper function.
// No dependencies.
package rdma_pkg;

    localparam int DATA_W   = 16;
    localparam int IDX_W    = 2;
    localparam int STREAK_W = 2;

    localparam logic [STREAK_W-1:0] STREAK_MAX = 2'd3;
    localparam logic [DATA_W-1:0]   CAP_RESET  = 16'hFFFF;

    localparam int SENSORS_DEF = 4;
    localparam int WINDOW_DEF  = 5;

    // running total width: room for WINDOW full-scale readings
    function automatic int total_w(input int window);
        return DATA_W + $clog2(window);
    endfunction

endpackage

FILE: src/rdma_if.sv
// Channel interfaces for the range dropout moving average block.
// Input readings, filtered results and the cap register write channel.
// Depends on rdma_pkg.
interface rdma_in_if;
    logic                        valid;
    logic                        ready;
    logic [rdma_pkg::IDX_W-1:0]  sensor_index;
    logic [rdma_pkg::DATA_W-1:0] range_value;

    modport source (output valid, sensor_index, range_value, input ready);
    modport sink   (input valid, sensor_index, range_value, output ready);
endinterface

interface rdma_out_if;
    logic                        valid;
    logic                        ready;
    logic [rdma_pkg::IDX_W-1:0]  sensor_out;
    logic [rdma_pkg::DATA_W-1:0] filtered_cm;
    logic                        updated;

    modport source (output valid, sensor_out, filtered_cm, updated, input ready);
    modport sink   (input valid, sensor_out, filtered_cm, updated, output ready);
endinterface

interface rdma_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rdma_pkg::DATA_W-1:0] value_cap;

    modport source (output valid, value_cap, input ready);
    modport sink   (input valid, value_cap, output ready);
endinterface

FILE: src/rdma_round.sv
// Rounded mean of a window total: floor((2*total + WINDOW) / (2*WINDOW)).
// Constant division done as one multiply by a rounded-up reciprocal.
// Depends on rdma_pkg.
module rdma_round #(
    parameter int  WINDOW = rdma_pkg::WINDOW_DEF,
    localparam int TW     = rdma_pkg::total_w(WINDOW)
) (
    input  logic [TW-1:0]               i_total,
    output logic [rdma_pkg::DATA_W-1:0] o_avg
);

    localparam int XW = TW + 1;
    localparam int L  = $clog2(2 * WINDOW);
    localparam int S  = XW + L;
    localparam int MW = XW + 2;
    localparam int PW = XW + MW;
    localparam int QW = PW - S;

    localparam logic [63:0] DIVISOR = 64'(2 * WINDOW);
    localparam logic [63:0] RECIP   = ((64'd1 << S) + DIVISOR - 64'd1) / DIVISOR;

    logic [XW-1:0] x;
    logic [PW-1:0] prod;
    logic [QW-1:0] quot;

    assign x    = {i_total, 1'b0} + XW'(WINDOW);
    assign prod = {{MW{1'b0}}, x} * {{XW{1'b0}}, RECIP[MW-1:0]};
    assign quot = prod[PW-1:S];

    assign o_avg = (|quot[QW-1:rdma_pkg::DATA_W]) ? {rdma_pkg::DATA_W{1'b1}}
                                                  : quot[rdma_pkg::DATA_W-1:0];

endmodule

FILE: src/rdma_filt.sv
// Per-sensor filter state: ring buffers, write slots, running totals, zero streaks.
// Applies one reading per cycle while i_go is high and returns the new total (held total if suppressed).
// Depends on rdma_pkg.
module rdma_filt #(
    parameter int  SENSORS = rdma_pkg::SENSORS_DEF,
    parameter int  WINDOW  = rdma_pkg::WINDOW_DEF,
    localparam int TW      = rdma_pkg::total_w(WINDOW)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [rdma_pkg::IDX_W-1:0]  i_sensor,
    input  logic [rdma_pkg::DATA_W-1:0] i_range,
    output logic [TW-1:0]               o_total,
    output logic                        o_updated
);

    localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [rdma_pkg::DATA_W-1:0]   r_win    [SENSORS][WINDOW];
    logic [PW-1:0]                 r_slot   [SENSORS];
    logic [TW-1:0]                 r_total  [SENSORS];
    logic [rdma_pkg::STREAK_W-1:0] r_streak [SENSORS];

    logic                        in_rng;
    logic [SW-1:0]               sel;
    logic [PW-1:0]               cur_slot;
    logic [PW-1:0]               n_slot;
    logic [rdma_pkg::DATA_W-1:0] old_val;
    logic                        zero;
    logic                        suppress;
    logic [TW-1:0]               n_total;

    assign in_rng   = {{(32-rdma_pkg::IDX_W){1'b0}}, i_sensor} < 32'(SENSORS);
    assign sel      = SW'(i_sensor);
    assign cur_slot = r_slot[sel];
    assign old_val  = r_win[sel][cur_slot];
    assign zero     = (i_range == '0);
    assign suppress = zero && (r_streak[sel] != rdma_pkg::STREAK_MAX);
    assign n_total  = r_total[sel] - TW'(old_val) + TW'(i_range);
    assign n_slot   = (cur_slot == PW'(WINDOW - 1)) ? '0 : cur_slot + 1'b1;

    assign o_updated = in_rng && !suppress;
    assign o_total   = !in_rng  ? '0 :
                       suppress ? r_total[sel] : n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSORS; s++) begin
                r_slot[s]   <= '0;
                r_total[s]  <= '0;
                r_streak[s] <= '0;
                for (int w = 0; w < WINDOW; w++) begin
                    r_win[s][w] <= '0;
                end
            end
        end else if (i_go && o_updated) begin
            r_win[sel][cur_slot] <= i_range;
            r_slot[sel]          <= n_slot;
            r_total[sel]         <= n_total;
            if (!zero) begin
                r_streak[sel] <= '0;
            end
        end else if (i_go && in_rng && suppress) begin
            r_streak[sel] <= r_streak[sel] + 1'b1;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_rng |-> (32'(cur_slot) < WINDOW))
        else $error("write slot out of window");

    a_streak_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && in_rng && suppress) |=>
        (r_streak[$past(sel)] == $past(r_streak[sel]) + 1'b1))
        else $error("suppressed zero did not advance streak");

    a_streak_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_updated && !zero) |=> (r_streak[$past(sel)] == '0))
        else $error("nonzero reading did not clear streak");

    a_total_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_updated) |=> (r_total[$past(sel)] == $past(o_total)))
        else $error("running total not stored");

endmodule

FILE: src/range_dropout_moving_average_top.sv
// Range dropout moving average: per-sensor moving average with zero-dropout reject.
// Three-register pipeline: input register, filter update, rounding and cap.
// Depends on rdma_pkg, rdma_if, rdma_filt and rdma_round.
//
// Usage: i_in carries one range reading per transfer, tagged with its sensor.
// Each transfer on i_in produces exactly one transfer on o_out, in order,
// carrying the sensor, its held average limited to the cap, and whether the
// reading entered the average (isolated zeros up to three in a row do not).
// i_cfg writes the cap and is always ready; the user writes it only while the
// block is idle, which the block itself does not enforce. Each reading is
// registered in the input, filter and output stages. Throughput: one reading
// per cycle unless o_out stalls, set by the read-update-write of per-sensor state.
// Reset clears all ring buffers, totals, slots and streaks to zero and sets
// the cap to 65535. When the receiver stalls, the output holds and the stages
// behind it fill; i_in.ready drops once all three registers are occupied.
module range_dropout_moving_average_top #(
    parameter int SENSORS = rdma_pkg::SENSORS_DEF,
    parameter int WINDOW  = rdma_pkg::WINDOW_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rdma_in_if.sink        i_in,
    rdma_out_if.source     o_out,
    rdma_cfg_if.sink       i_cfg
);

    localparam int TW = rdma_pkg::total_w(WINDOW);

    logic [rdma_pkg::DATA_W-1:0] r_cap;

    logic                        r1_vld;
    logic [rdma_pkg::IDX_W-1:0]  r1_sensor;
    logic [rdma_pkg::DATA_W-1:0] r1_range;

    logic                        r2_vld;
    logic [rdma_pkg::IDX_W-1:0]  r2_sensor;
    logic [TW-1:0]               r2_total;
    logic                        r2_upd;

    logic                        r3_vld;
    logic [rdma_pkg::IDX_W-1:0]  r3_sensor;
    logic [rdma_pkg::DATA_W-1:0] r3_filt;
    logic                        r3_upd;

    logic                        en1, en2, en3;
    logic                        go;
    logic [TW-1:0]               f_total;
    logic                        f_upd;
    logic [rdma_pkg::DATA_W-1:0] avg;
    logic [rdma_pkg::DATA_W-1:0] capped;

    assign en3 = !r3_vld || o_out.ready;
    assign en2 = !r2_vld || en3;
    assign en1 = !r1_vld || en2;
    assign go  = r1_vld && en2;

    assign i_in.ready  = en1;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= rdma_pkg::CAP_RESET;
        end else if (i_cfg.valid) begin
            r_cap <= i_cfg.value_cap;
        end
    end

    rdma_filt #(
        .SENSORS (SENSORS),
        .WINDOW  (WINDOW)
    ) u_filt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_sensor  (r1_sensor),
        .i_range   (r1_range),
        .o_total   (f_total),
        .o_updated (f_upd)
    );

    rdma_round #(
        .WINDOW (WINDOW)
    ) u_round (
        .i_total (r2_total),
        .o_avg   (avg)
    );

    assign capped = (avg < r_cap) ? avg : r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (en1) begin
                r1_vld <= i_in.valid;
            end
            if (en2) begin
                r2_vld <= r1_vld;
            end
            if (en3) begin
                r3_vld <= r2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in.valid) begin
            r1_sensor <= i_in.sensor_index;
            r1_range  <= i_in.range_value;
        end
        if (go) begin
            r2_sensor <= r1_sensor;
            r2_total  <= f_total;
            r2_upd    <= f_upd;
        end
        if (en3 && r2_vld) begin
            r3_sensor <= r2_sensor;
            r3_filt   <= capped;
            r3_upd    <= r2_upd;
        end
    end

    assign o_out.valid       = r3_vld;
    assign o_out.sensor_out  = r3_sensor;
    assign o_out.filtered_cm = r3_filt;
    assign o_out.updated     = r3_upd;

endmodule

FILE: sim/range_dropout_moving_average_top_test.sv
// Self-checking testbench for range_dropout_moving_average_top: a directed table, then random
// readings under several cap settings, checked against a per-sensor moving average predictor.
// Depends on rdma_pkg, rdma_if and the block RTL.
module range_dropout_moving_average_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SENSOR_COUNT   = rdma_pkg::SENSORS_DEF;
    localparam int WINDOW_LEN     = rdma_pkg::WINDOW_DEF;
    localparam int SENSOR_W       = rdma_pkg::IDX_W;
    localparam int RANGE_W        = rdma_pkg::DATA_W;
    localparam int IDLE_PCT       = 17;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        logic [RANGE_W-1:0]  cm;
        logic                updated;
    } t_range_result;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor;
        logic [RANGE_W-1:0]  value;
        logic                known;
        logic [RANGE_W-1:0]  cm;
        logic                updated;
    } t_reading_row;

    localparam int DIRECTED_ROWS = 21;
    localparam t_reading_row DIRECTED [DIRECTED_ROWS] = '{
        '{2'd0, 16'd0,      1'b1, 16'd0,     1'b0},
        '{2'd0, 16'd0,      1'b1, 16'd0,     1'b0},
        '{2'd0, 16'd0,      1'b1, 16'd0,     1'b0},
        '{2'd0, 16'd0,      1'b1, 16'd0,     1'b1},  // fourth zero in a row enters
        '{2'd0, 16'd0,      1'b1, 16'd0,     1'b1},  // streak saturated
        '{2'd0, 16'd5,      1'b1, 16'd1,     1'b1},
        '{2'd0, 16'd0,      1'b1, 16'd1,     1'b0},  // streak cleared by nonzero
        '{2'd1, 16'hFFFF,   1'b0, 16'd0,     1'b0},
        '{2'd1, 16'hFFFF,   1'b0, 16'd0,     1'b0},
        '{2'd1, 16'hFFFF,   1'b0, 16'd0,     1'b0},
        '{2'd1, 16'hFFFF,   1'b0, 16'd0,     1'b0},
        '{2'd1, 16'hFFFF,   1'b1, 16'hFFFF,  1'b1},  // full window at max
        '{2'd1, 16'd0,      1'b1, 16'hFFFF,  1'b0},
        '{2'd2, 16'd2,      1'b0, 16'd0,     1'b0},
        '{2'd2, 16'd1,      1'b0, 16'd0,     1'b0},
        '{2'd2, 16'hAAAA,   1'b0, 16'd0,     1'b0},
        '{2'd3, 16'h5555,   1'b0, 16'd0,     1'b0},
        '{2'd3, 16'hAAAA,   1'b0, 16'd0,     1'b0},
        '{2'd3, 16'd1,      1'b0, 16'd0,     1'b0},
        '{2'd2, 16'd0,      1'b0, 16'd0,     1'b0},
        '{2'd3, 16'hFFFF,   1'b0, 16'd0,     1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    always #10 clk = ~clk;

    rdma_in_if  in_ch ();
    rdma_out_if out_ch ();
    rdma_cfg_if cfg_ch ();

    range_dropout_moving_average_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    logic [RANGE_W-1:0]            window_mem   [SENSOR_COUNT][WINDOW_LEN];
    int unsigned                   next_slot    [SENSOR_COUNT];
    logic [31:0]                   window_sum   [SENSOR_COUNT];
    logic [rdma_pkg::STREAK_W-1:0] zero_run     [SENSOR_COUNT];
    logic [RANGE_W-1:0]            average_held [SENSOR_COUNT];
    logic [RANGE_W-1:0]            cap_limit;

    t_range_result expected_results [$];
    int            mismatch_count;
    int            cycle_count;
    bit            steady;

    function automatic void clear_filter_state();
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            for (int w = 0; w < WINDOW_LEN; w++) begin
                window_mem[s][w] = '0;
            end
            next_slot[s]    = 0;
            window_sum[s]   = '0;
            zero_run[s]     = '0;
            average_held[s] = '0;
        end
        cap_limit = rdma_pkg::CAP_RESET;
    endfunction

    function automatic t_range_result filter_reading(input logic [SENSOR_W-1:0] s,
                                                     input logic [RANGE_W-1:0] v);
        t_range_result r;
        logic [31:0]   q;
        int unsigned   slot;
        r.sensor = s;
        if (v == '0 && zero_run[s] < rdma_pkg::STREAK_MAX) begin
            zero_run[s] = zero_run[s] + 1'b1;
            r.updated   = 1'b0;
        end else begin
            slot                 = next_slot[s];
            window_sum[s]        = window_sum[s] - window_mem[s][slot] + v;
            window_mem[s][slot]  = v;
            next_slot[s]         = (slot + 1 == WINDOW_LEN) ? 0 : slot + 1;
            // round half up: floor((2*sum + N) / 2N)
            q = (2 * window_sum[s] + WINDOW_LEN) / (2 * WINDOW_LEN);
            average_held[s] = (q > 32'hFFFF) ? '1 : q[RANGE_W-1:0];
            if (v != '0) begin
                zero_run[s] = '0;
            end
            r.updated = 1'b1;
        end
        r.cm = (average_held[s] < cap_limit) ? average_held[s] : cap_limit;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return '0;
        if (roll < 35) return '1;
        if (roll < 55) return RANGE_W'($urandom_range(1, 40));
        if (roll < 65) return RANGE_W'($urandom_range(65500, 65534));
        return RANGE_W'($urandom);
    endfunction

    task automatic send_reading(input logic [SENSOR_W-1:0] s, input logic [RANGE_W-1:0] v,
                                input logic known, input logic [RANGE_W-1:0] known_cm,
                                input logic known_updated);
        t_range_result predicted;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sensor_index <= s;
        in_ch.range_value  <= v;
        do @(posedge clk); while (!in_ch.ready);
        predicted = filter_reading(s, v);
        if (known) begin
            predicted.cm      = known_cm;
            predicted.updated = known_updated;
        end
        expected_results.push_back(predicted);
    endtask

    // sender holds off until every result is back, then waits out the pipeline
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cap(input logic [RANGE_W-1:0] v);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.value_cap <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cap_limit = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int items);
        int                  sent;
        int                  run_len;
        int unsigned         roll;
        logic [SENSOR_W-1:0] s;
        logic [RANGE_W-1:0]  level;
        sent = 0;
        while (sent < items) begin
            s    = SENSOR_W'($urandom_range(0, SENSOR_COUNT - 1));
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                run_len = $urandom_range(1, 6);
                repeat (run_len) send_reading(s, '0, 1'b0, '0, 1'b0);
                sent += run_len;
            end else if (roll < 30) begin
                level = RANGE_W'($urandom);
                repeat (WINDOW_LEN) begin
                    send_reading(s, level ^ RANGE_W'($urandom_range(0, 15)), 1'b0, '0, 1'b0);
                end
                sent += WINDOW_LEN;
            end else begin
                send_reading(s, pick_range(), 1'b0, '0, 1'b0);
                sent++;
            end
        end
    endtask

    always @(posedge clk) begin : result_check
        t_range_result oldest;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected transfer: sensor %0d cm %0d updated %0d",
                                       out_ch.sensor_out, out_ch.filtered_cm, out_ch.updated));
            end else begin
                oldest = expected_results.pop_front();
                if (out_ch.sensor_out !== oldest.sensor || out_ch.filtered_cm !== oldest.cm
                        || out_ch.updated !== oldest.updated) begin
                    note_failure($sformatf(
                        "got sensor %0d cm %0d updated %0d, exp sensor %0d cm %0d updated %0d",
                        out_ch.sensor_out, out_ch.filtered_cm, out_ch.updated,
                        oldest.sensor, oldest.cm, oldest.updated));
                end
            end
        end
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("range_dropout_moving_average_top verification failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.sensor_index = '0;
        in_ch.range_value  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.value_cap   = '0;
        out_ch.ready       = 1'b0;
        rst_n              = 1'b0;
        steady             = 1'b0;
        mismatch_count     = 0;
        cycle_count        = 0;
        clear_filter_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            send_reading(DIRECTED[i].sensor, DIRECTED[i].value, DIRECTED[i].known,
                         DIRECTED[i].cm, DIRECTED[i].updated);
        end
        drain_results();

        write_cap('0);
        run_phase(150);
        drain_results();

        write_cap(RANGE_W'($urandom_range(1, 2000)));
        run_phase(300);
        drain_results();

        write_cap(RANGE_W'($urandom));
        steady = 1'b1;
        run_phase(250);
        drain_results();
        steady = 1'b0;

        write_cap('1);
        run_phase(280);
        drain_results();

        write_cap(RANGE_W'($urandom_range(100, 1000)));
        run_phase(150);
        drain_results();

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("range_dropout_moving_average_top verification clean");
        end else begin
            $display("range_dropout_moving_average_top verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/rdma_pkg.sv
src/rdma_if.sv
src/rdma_round.sv
src/rdma_filt.sv
src/range_dropout_moving_average_top.sv
sim/range_dropout_moving_average_top_test.sv
